@@ hdl/gmvn_pkg.sv @@
// ----------------------------------------------------------------------------
// gmvn_pkg
// Shared types, widths and helpers for the grid mesh vertex normal core.
// ----------------------------------------------------------------------------
package gmvn_pkg;

  localparam int unsigned DIM_W   = 7;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned SUM_W   = 18;
  localparam int unsigned VEC_W   = 31;
  localparam int unsigned CNT_MIN_W = 13;

  localparam logic [DIM_W-1:0] DIM_MIN = 7'd2;
  localparam logic [DIM_W-1:0] DIM_MAX = 7'd64;
  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;
  localparam logic [15:0] UNIT_ONE = 16'd16384;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_CAP,
    OP_CLR,
    OP_FETCH,
    OP_N_E1,
    OP_N_E2,
    OP_CROSS,
    OP_N_F,
    OP_ACC,
    OP_NEXT,
    OP_RD_REQ,
    OP_N_RD,
    OP_OUT,
    OP_OUT0
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] sub;
  } dp_cmd_t;

  typedef struct packed {
    logic load_last;
    logic clr_last;
    logic skip;
    logic tri_last;
    logic rd_ok;
    logic norm_done;
  } dp_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_TRI,
    ST_FETCH,
    ST_E1,
    ST_E1_W,
    ST_E2,
    ST_E2_W,
    ST_CROSS,
    ST_FACE,
    ST_FACE_W,
    ST_ACC,
    ST_NEXT,
    ST_RD_CHK,
    ST_RD_REQ,
    ST_RD_NORM,
    ST_RD_W,
    ST_RD_OUT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SQ,
    N_ZCHK,
    N_SHIFT,
    N_ROOT,
    N_DSET,
    N_DSTEP,
    N_DONE
  } norm_state_e;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < DIM_MIN) r = DIM_MIN;
    else if (v > DIM_MAX) r = DIM_MAX;
    return r;
  endfunction

endpackage

@@ hdl/gmvn_norm.sv @@
// ----------------------------------------------------------------------------
// gmvn_norm
// Iterative unit vector: sum of squares, scale, bitwise root, one divider run per component.
// ----------------------------------------------------------------------------
module gmvn_norm (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [gmvn_pkg::VEC_W-1:0]  vec_i [3],
  output logic                               done_o,
  output logic signed [gmvn_pkg::UNIT_W-1:0] unit_o [3]
);

  gmvn_pkg::norm_state_e st_q, st_d;

  logic [31:0] m_q [3];
  logic [2:0]  neg_q;
  logic [63:0] s_q, r_q, b_q;
  logic [1:0]  j_q;
  logic [3:0]  n_q;
  logic [32:0] rem_q;
  logic [15:0] num_q, quo_q;
  logic signed [gmvn_pkg::UNIT_W-1:0] o_q [3];

  logic [gmvn_pkg::VEC_W-1:0] mag_in [3];
  logic [63:0] sq;
  logic [63:0] trial;
  logic [47:0] num;
  logic [33:0] rem2;
  logic [33:0] dvs;
  logic        ge;
  logic [15:0] quo_n, quo_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = vec_i[i][gmvn_pkg::VEC_W-1] ? gmvn_pkg::VEC_W'(-vec_i[i]) : vec_i[i];
    end
    sq    = m_q[j_q] * m_q[j_q];
    trial = r_q + b_q;
    num   = {1'b0, m_q[j_q], 15'b0} + {16'b0, r_q[31:0]};
    rem2  = {rem_q, num_q[15]};
    dvs   = {1'b0, r_q[31:0], 1'b0};
    ge    = rem2 >= dvs;
    quo_n = {quo_q[14:0], ge};
    quo_c = (quo_n > gmvn_pkg::UNIT_ONE) ? gmvn_pkg::UNIT_ONE : quo_n;
  end

  always_comb begin
    st_d   = st_q;
    done_o = 1'b0;
    unique case (st_q)
      gmvn_pkg::N_IDLE:  if (start_i) st_d = gmvn_pkg::N_SQ;
      gmvn_pkg::N_SQ:    if (j_q == 2'd2) st_d = gmvn_pkg::N_ZCHK;
      gmvn_pkg::N_ZCHK:  st_d = (s_q == '0) ? gmvn_pkg::N_DONE : gmvn_pkg::N_SHIFT;
      gmvn_pkg::N_SHIFT: if (s_q[63:60] != 4'd0) st_d = gmvn_pkg::N_ROOT;
      gmvn_pkg::N_ROOT:  if (b_q[0]) st_d = gmvn_pkg::N_DSET;
      gmvn_pkg::N_DSET:  st_d = gmvn_pkg::N_DSTEP;
      gmvn_pkg::N_DSTEP: begin
        if (n_q == 4'd15) st_d = (j_q == 2'd2) ? gmvn_pkg::N_DONE : gmvn_pkg::N_DSET;
      end
      gmvn_pkg::N_DONE: begin
        st_d   = gmvn_pkg::N_IDLE;
        done_o = 1'b1;
      end
      default: st_d = gmvn_pkg::N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= gmvn_pkg::N_IDLE;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      gmvn_pkg::N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            neg_q[i] <= vec_i[i][gmvn_pkg::VEC_W-1];
            m_q[i]   <= {1'b0, mag_in[i]};
          end
          s_q <= '0;
          j_q <= 2'd0;
        end
      end
      gmvn_pkg::N_SQ: begin
        s_q <= s_q + sq;
        j_q <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
      end
      gmvn_pkg::N_ZCHK: begin
        if (s_q == '0) begin
          for (int i = 0; i < 3; i++) o_q[i] <= '0;
        end
      end
      gmvn_pkg::N_SHIFT: begin
        if (s_q[63:60] == 4'd0) begin
          s_q <= s_q << 2;
          for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
        end else begin
          r_q <= '0;
          b_q <= 64'h4000_0000_0000_0000;
        end
      end
      gmvn_pkg::N_ROOT: begin
        if (s_q >= trial) begin
          s_q <= s_q - trial;
          r_q <= (r_q >> 1) + b_q;
        end else begin
          r_q <= r_q >> 1;
        end
        b_q <= b_q >> 2;
      end
      gmvn_pkg::N_DSET: begin
        rem_q <= {1'b0, num[47:16]};
        num_q <= num[15:0];
        quo_q <= '0;
        n_q   <= '0;
      end
      gmvn_pkg::N_DSTEP: begin
        rem_q <= ge ? 33'(rem2 - dvs) : rem2[32:0];
        num_q <= num_q << 1;
        quo_q <= quo_n;
        n_q   <= n_q + 4'd1;
        if (n_q == 4'd15) begin
          o_q[j_q] <= neg_q[j_q] ? -$signed(quo_c) : $signed(quo_c);
          j_q      <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign unit_o = o_q;

endmodule

@@ hdl/gmvn_dp.sv @@
// ----------------------------------------------------------------------------
// gmvn_dp
// Datapath: vertex and normal sum memories, quad walk, cross product, output.
// ----------------------------------------------------------------------------
module gmvn_dp #(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gmvn_pkg::dp_cmd_t                   cmd_i,
  output gmvn_pkg::dp_stat_t                  stat_o,
  input  logic                                cfg_wr_i,
  input  logic [gmvn_pkg::DIM_W-1:0]          rows_i,
  input  logic [gmvn_pkg::DIM_W-1:0]          cols_i,
  input  logic signed [gmvn_pkg::COORD_W-1:0] vertex_x_i,
  input  logic signed [gmvn_pkg::COORD_W-1:0] vertex_y_i,
  input  logic signed [gmvn_pkg::COORD_W-1:0] vertex_z_i,
  input  logic [gmvn_pkg::IDX_W-1:0]          normal_index_i,
  output logic                                valid_o,
  output logic signed [gmvn_pkg::UNIT_W-1:0]  normal_x_o,
  output logic signed [gmvn_pkg::UNIT_W-1:0]  normal_y_o,
  output logic signed [gmvn_pkg::UNIT_W-1:0]  normal_z_o,
  output logic [gmvn_pkg::IDX_W-1:0]          read_index_o
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = (AW + 1 > gmvn_pkg::CNT_MIN_W) ? AW + 1 : gmvn_pkg::CNT_MIN_W;
  localparam logic [CW-1:0] MAXP = CW'(MAX_POINTS);
  localparam int unsigned CWD = gmvn_pkg::COORD_W;
  localparam int unsigned SW = gmvn_pkg::SUM_W;
  localparam int unsigned VW = gmvn_pkg::VEC_W;

  logic [3*CWD-1:0] vmem [MAX_POINTS];
  logic [3*SW-1:0]  smem [MAX_POINTS];

  logic [CW-1:0] load_cnt_q, clr_cnt_q, k_q;
  logic [5:0]    c_q, r_q;
  logic          tri_q, ready_q, valid_q;
  logic [gmvn_pkg::IDX_W-1:0] idx_q;

  logic [3*CWD-1:0] v_rd_q, vp_q, vq_q, vs_q;
  logic [3*SW-1:0]  s_rd_q;
  logic signed [gmvn_pkg::UNIT_W-1:0] n1_q [3];
  logic signed [VW-1:0] cr_q [3];
  logic signed [gmvn_pkg::UNIT_W-1:0] nx_q, ny_q, nz_q;

  logic [12:0]   prod;
  logic [CW-1:0] total, lim, cols_w, idx_ext;
  logic [CW-1:0] idx_p, idx_q1, idx_s, sel_idx;
  logic [1:0]    sel;
  logic          load_last;

  logic          v_we, v_re, s_we, s_re;
  logic [AW-1:0] v_wa, v_ra, s_wa, s_ra;
  logic [3*SW-1:0] s_wd;

  logic          n_start, n_done;
  logic signed [VW-1:0] n_vec [3];
  logic signed [gmvn_pkg::UNIT_W-1:0] unit [3];
  logic signed [VW-1:0] e1 [3], e2 [3];

  gmvn_pkg::dp_op_e op;

  assign op      = cmd_i.op;
  assign prod    = 13'(rows_i) * 13'(cols_i);
  assign total   = CW'(prod);
  assign lim     = (total < MAXP) ? total : MAXP;
  assign cols_w  = CW'(cols_i);
  assign idx_ext = CW'(idx_q);
  assign load_last = (load_cnt_q + CW'(1)) >= total;

  assign idx_p  = k_q;
  assign idx_q1 = tri_q ? k_q + CW'(1) : k_q + cols_w + CW'(1);
  assign idx_s  = tri_q ? k_q + cols_w + CW'(1) : k_q + cols_w;
  assign sel    = (op == gmvn_pkg::OP_FETCH) ? cmd_i.sub[1:0] : cmd_i.sub[2:1];

  always_comb begin
    unique case (sel)
      2'd0:    sel_idx = idx_p;
      2'd1:    sel_idx = idx_q1;
      default: sel_idx = idx_s;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = VW'($signed(vp_q[i*CWD +: CWD])) - VW'($signed(vs_q[i*CWD +: CWD]));
      e2[i] = VW'($signed(vp_q[i*CWD +: CWD])) - VW'($signed(vq_q[i*CWD +: CWD]));
    end
  end

  always_comb begin
    n_start = 1'b0;
    for (int i = 0; i < 3; i++) n_vec[i] = e1[i];
    unique case (op)
      gmvn_pkg::OP_N_E1: n_start = 1'b1;
      gmvn_pkg::OP_N_E2: begin
        n_start = 1'b1;
        for (int i = 0; i < 3; i++) n_vec[i] = e2[i];
      end
      gmvn_pkg::OP_N_F: begin
        n_start = 1'b1;
        for (int i = 0; i < 3; i++) n_vec[i] = cr_q[i];
      end
      gmvn_pkg::OP_N_RD: begin
        n_start = 1'b1;
        for (int i = 0; i < 3; i++) n_vec[i] = VW'($signed(s_rd_q[i*SW +: SW]));
      end
      default: ;
    endcase
  end

  gmvn_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (n_start),
    .vec_i   (n_vec),
    .done_o  (n_done),
    .unit_o  (unit)
  );

  always_comb begin
    v_we = 1'b0;
    v_re = 1'b0;
    s_we = 1'b0;
    s_re = 1'b0;
    v_wa = load_cnt_q[AW-1:0];
    v_ra = sel_idx[AW-1:0];
    s_wa = sel_idx[AW-1:0];
    s_ra = sel_idx[AW-1:0];
    s_wd = '0;
    for (int i = 0; i < 3; i++) begin
      s_wd[i*SW +: SW] = s_rd_q[i*SW +: SW] + SW'(unit[i]);
    end
    unique case (op)
      gmvn_pkg::OP_LOAD:  v_we = load_cnt_q < MAXP;
      gmvn_pkg::OP_FETCH: v_re = cmd_i.sub[1:0] != 2'd3;
      gmvn_pkg::OP_CLR: begin
        s_we = 1'b1;
        s_wa = clr_cnt_q[AW-1:0];
        s_wd = '0;
      end
      gmvn_pkg::OP_ACC: begin
        s_re = !cmd_i.sub[0];
        s_we = cmd_i.sub[0];
      end
      gmvn_pkg::OP_RD_REQ: begin
        s_re = 1'b1;
        s_ra = idx_ext[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (v_we) vmem[v_wa] <= {vertex_z_i, vertex_y_i, vertex_x_i};
    if (v_re) v_rd_q <= vmem[v_ra];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) smem[s_wa] <= s_wd;
    if (s_re) s_rd_q <= smem[s_ra];
  end

  always_ff @(posedge clk_i) begin
    unique case (op)
      gmvn_pkg::OP_RD_CAP: idx_q <= normal_index_i;
      gmvn_pkg::OP_FETCH: begin
        if (cmd_i.sub[1:0] == 2'd1) vp_q <= v_rd_q;
        if (cmd_i.sub[1:0] == 2'd2) vq_q <= v_rd_q;
        if (cmd_i.sub[1:0] == 2'd3) vs_q <= v_rd_q;
      end
      gmvn_pkg::OP_N_E2: n1_q <= unit;
      gmvn_pkg::OP_CROSS: begin
        unique case (cmd_i.sub[1:0])
          2'd0:    cr_q[0] <= VW'(32'(n1_q[1] * unit[2]) - 32'(n1_q[2] * unit[1]));
          2'd1:    cr_q[1] <= VW'(32'(n1_q[2] * unit[0]) - 32'(n1_q[0] * unit[2]));
          default: cr_q[2] <= VW'(32'(n1_q[0] * unit[1]) - 32'(n1_q[1] * unit[0]));
        endcase
      end
      gmvn_pkg::OP_OUT: begin
        nx_q <= -unit[0];
        ny_q <= -unit[1];
        nz_q <= -unit[2];
      end
      gmvn_pkg::OP_OUT0: begin
        nx_q <= '0;
        ny_q <= '0;
        nz_q <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      clr_cnt_q  <= '0;
      k_q        <= '0;
      c_q        <= '0;
      r_q        <= '0;
      tri_q      <= 1'b0;
      ready_q    <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      valid_q <= (op == gmvn_pkg::OP_OUT) || (op == gmvn_pkg::OP_OUT0);
      if (cfg_wr_i) begin
        load_cnt_q <= '0;
        ready_q    <= 1'b0;
      end
      unique case (op)
        gmvn_pkg::OP_LOAD: begin
          if (load_cnt_q == '0) ready_q <= 1'b0;
          load_cnt_q <= load_last ? '0 : load_cnt_q + CW'(1);
          clr_cnt_q  <= '0;
          k_q        <= '0;
          c_q        <= '0;
          r_q        <= '0;
          tri_q      <= 1'b0;
        end
        gmvn_pkg::OP_CLR: clr_cnt_q <= clr_cnt_q + CW'(1);
        gmvn_pkg::OP_NEXT: begin
          tri_q <= !tri_q;
          if (tri_q) begin
            if (c_q == 6'(cols_i - 7'd2)) begin
              c_q <= '0;
              r_q <= r_q + 6'd1;
              k_q <= k_q + CW'(2);
            end else begin
              c_q <= c_q + 6'd1;
              k_q <= k_q + CW'(1);
            end
          end
          if (stat_o.tri_last) ready_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign stat_o.load_last = load_last;
  assign stat_o.clr_last  = clr_cnt_q == (lim - CW'(1));
  assign stat_o.skip      = (k_q + cols_w + CW'(1)) >= MAXP;
  assign stat_o.tri_last  = tri_q && (r_q == 6'(rows_i - 7'd2)) && (c_q == 6'(cols_i - 7'd2));
  assign stat_o.rd_ok     = ready_q && (idx_ext < total) && (idx_ext < MAXP);
  assign stat_o.norm_done = n_done;

  assign valid_o      = valid_q;
  assign normal_x_o   = nx_q;
  assign normal_y_o   = ny_q;
  assign normal_z_o   = nz_q;
  assign read_index_o = idx_q;

endmodule

@@ hdl/gmvn_ctrl.sv @@
// ----------------------------------------------------------------------------
// gmvn_ctrl
// Controller: sequences loads, the sum clear, the triangle walk and reads.
// ----------------------------------------------------------------------------
module gmvn_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               mode_i,
  input  gmvn_pkg::dp_stat_t stat_i,
  output gmvn_pkg::dp_cmd_t  cmd_o,
  output logic               busy_o
);

  gmvn_pkg::ctrl_state_e st_q, st_d;
  logic [2:0] sub_q, sub_d;

  always_comb begin
    st_d      = st_q;
    sub_d     = 3'd0;
    cmd_o.op  = gmvn_pkg::OP_NONE;
    cmd_o.sub = sub_q;
    busy_o    = st_q != gmvn_pkg::ST_IDLE;
    unique case (st_q)
      gmvn_pkg::ST_IDLE: begin
        if (start_i) begin
          if (mode_i) begin
            cmd_o.op = gmvn_pkg::OP_RD_CAP;
            st_d     = gmvn_pkg::ST_RD_CHK;
          end else begin
            cmd_o.op = gmvn_pkg::OP_LOAD;
            if (stat_i.load_last) st_d = gmvn_pkg::ST_CLEAR;
          end
        end
      end
      gmvn_pkg::ST_CLEAR: begin
        cmd_o.op = gmvn_pkg::OP_CLR;
        if (stat_i.clr_last) st_d = gmvn_pkg::ST_TRI;
      end
      gmvn_pkg::ST_TRI: st_d = stat_i.skip ? gmvn_pkg::ST_NEXT : gmvn_pkg::ST_FETCH;
      gmvn_pkg::ST_FETCH: begin
        cmd_o.op = gmvn_pkg::OP_FETCH;
        sub_d    = sub_q + 3'd1;
        if (sub_q == 3'd3) begin
          st_d  = gmvn_pkg::ST_E1;
          sub_d = 3'd0;
        end
      end
      gmvn_pkg::ST_E1: begin
        cmd_o.op = gmvn_pkg::OP_N_E1;
        st_d     = gmvn_pkg::ST_E1_W;
      end
      gmvn_pkg::ST_E1_W: if (stat_i.norm_done) st_d = gmvn_pkg::ST_E2;
      gmvn_pkg::ST_E2: begin
        cmd_o.op = gmvn_pkg::OP_N_E2;
        st_d     = gmvn_pkg::ST_E2_W;
      end
      gmvn_pkg::ST_E2_W: if (stat_i.norm_done) st_d = gmvn_pkg::ST_CROSS;
      gmvn_pkg::ST_CROSS: begin
        cmd_o.op = gmvn_pkg::OP_CROSS;
        sub_d    = sub_q + 3'd1;
        if (sub_q == 3'd2) begin
          st_d  = gmvn_pkg::ST_FACE;
          sub_d = 3'd0;
        end
      end
      gmvn_pkg::ST_FACE: begin
        cmd_o.op = gmvn_pkg::OP_N_F;
        st_d     = gmvn_pkg::ST_FACE_W;
      end
      gmvn_pkg::ST_FACE_W: if (stat_i.norm_done) st_d = gmvn_pkg::ST_ACC;
      gmvn_pkg::ST_ACC: begin
        cmd_o.op = gmvn_pkg::OP_ACC;
        sub_d    = sub_q + 3'd1;
        if (sub_q == 3'd5) begin
          st_d  = gmvn_pkg::ST_NEXT;
          sub_d = 3'd0;
        end
      end
      gmvn_pkg::ST_NEXT: begin
        cmd_o.op = gmvn_pkg::OP_NEXT;
        st_d     = stat_i.tri_last ? gmvn_pkg::ST_IDLE : gmvn_pkg::ST_TRI;
      end
      gmvn_pkg::ST_RD_CHK: begin
        if (stat_i.rd_ok) begin
          st_d = gmvn_pkg::ST_RD_REQ;
        end else begin
          cmd_o.op = gmvn_pkg::OP_OUT0;
          st_d     = gmvn_pkg::ST_IDLE;
        end
      end
      gmvn_pkg::ST_RD_REQ: begin
        cmd_o.op = gmvn_pkg::OP_RD_REQ;
        st_d     = gmvn_pkg::ST_RD_NORM;
      end
      gmvn_pkg::ST_RD_NORM: begin
        cmd_o.op = gmvn_pkg::OP_N_RD;
        st_d     = gmvn_pkg::ST_RD_W;
      end
      gmvn_pkg::ST_RD_W: if (stat_i.norm_done) st_d = gmvn_pkg::ST_RD_OUT;
      gmvn_pkg::ST_RD_OUT: begin
        cmd_o.op = gmvn_pkg::OP_OUT;
        st_d     = gmvn_pkg::ST_IDLE;
      end
      default: st_d = gmvn_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= gmvn_pkg::ST_IDLE;
      sub_q <= 3'd0;
    end else begin
      st_q  <= st_d;
      sub_q <= sub_d;
    end
  end

endmodule

@@ hdl/grid_mesh_vertex_normals_core.sv @@
// ----------------------------------------------------------------------------
// grid_mesh_vertex_normals_core
// Smooth per-vertex normals of a regular grid mesh, Q8.8 in, Q1.14 out.
// ----------------------------------------------------------------------------
// Usage: set grid_rows (0x0) and grid_cols (0x4) over APB while idle; each
// write restarts vertex loading. Issue a beat with start high while busy is
// low. mode_i low loads the next vertex (row-major, column fastest) and gives
// no result. The load that completes the grid raises busy for the whole
// normal pass: a clear sweep of the rows*cols sum entries (at most
// MAX_POINTS), then per triangle a setup, the vertex fetch, unit-vector runs
// of both edges, the cross product, a unit-vector run of the face normal,
// the accumulate into its three corner sums and the advance; a skipped
// triangle goes straight to the advance. There are two triangles per quad.
// All runs use the shared iterative unit-vector unit (square sum, scale
// search, 32-step root, then a 16-step divider run once per component).
// mode_i high reads the normal of normal_index_i: valid_o pulses for one cycle
// with the negated unit normal and the echoed index, or with a zero normal
// when the grid is not ready or the index lies outside it. The receiver cannot
// stall. Reset clears the controller, counters and ready flag; the sum memory
// is cleared by the sweep before each pass, the vertex memory is never cleared.
// ----------------------------------------------------------------------------
module grid_mesh_vertex_normals_core #(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode_i,
  input  logic signed [gmvn_pkg::COORD_W-1:0] vertex_x_i,
  input  logic signed [gmvn_pkg::COORD_W-1:0] vertex_y_i,
  input  logic signed [gmvn_pkg::COORD_W-1:0] vertex_z_i,
  input  logic [gmvn_pkg::IDX_W-1:0]          normal_index_i,
  output logic                                valid_o,
  output logic signed [gmvn_pkg::UNIT_W-1:0]  normal_x_o,
  output logic signed [gmvn_pkg::UNIT_W-1:0]  normal_y_o,
  output logic signed [gmvn_pkg::UNIT_W-1:0]  normal_z_o,
  output logic [gmvn_pkg::IDX_W-1:0]          read_index_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [gmvn_pkg::DIM_W-1:0] rows_q, cols_q;
  logic cfg_wr;
  gmvn_pkg::dp_cmd_t  cmd;
  gmvn_pkg::dp_stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = {25'b0, (paddr[2] == gmvn_pkg::REG_COLS) ? cols_q : rows_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= gmvn_pkg::DIM_RESET;
      cols_q <= gmvn_pkg::DIM_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == gmvn_pkg::REG_ROWS) rows_q <= pwdata[gmvn_pkg::DIM_W-1:0];
      else cols_q <= pwdata[gmvn_pkg::DIM_W-1:0];
    end
  end

  gmvn_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .mode_i  (mode_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  gmvn_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .cfg_wr_i       (cfg_wr),
    .rows_i         (gmvn_pkg::clamp_dim(rows_q)),
    .cols_i         (gmvn_pkg::clamp_dim(cols_q)),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .vertex_z_i     (vertex_z_i),
    .normal_index_i (normal_index_i),
    .valid_o        (valid_o),
    .normal_x_o     (normal_x_o),
    .normal_y_o     (normal_y_o),
    .normal_z_o     (normal_z_o),
    .read_index_o   (read_index_o)
  );

  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  a_read_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i) |=> busy)
    else $error("read beat did not start a read sequence");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (normal_x_o >= -16'sd16384 && normal_x_o <= 16'sd16384 &&
                 normal_y_o >= -16'sd16384 && normal_y_o <= 16'sd16384 &&
                 normal_z_o >= -16'sd16384 && normal_z_o <= 16'sd16384))
    else $error("normal component outside unit range");

endmodule
